FILE: rtl/hbv_pkg.sv
// Shared types, register indexes and constant functions for the
// Herschel-Bulkley viscosity pipeline. No dependencies.
package hbv_pkg;

   localparam logic [2:0] REG_MIN_RATE      = 3'd0;
   localparam logic [2:0] REG_MAX_RATE      = 3'd1;
   localparam logic [2:0] REG_CONSISTENCY   = 3'd2;
   localparam logic [2:0] REG_FLOW_EXPONENT = 3'd3;
   localparam logic [2:0] REG_YIELD_LEVEL   = 3'd4;

   localparam logic [31:0] MIN_RATE_RESET      = 32'd66;
   localparam logic [31:0] MAX_RATE_RESET      = 32'd65536000;
   localparam logic [31:0] CONSISTENCY_RESET   = 32'd65536;
   localparam logic [15:0] FLOW_EXPONENT_RESET = 16'd4096;
   localparam logic [31:0] YIELD_LEVEL_RESET   = 32'd0;

   localparam int LOG_STEPS = 16;
   localparam int EXP_STEPS = 16;
   localparam int DIV_STEPS = 32;

   // Item in flight through the log2 cells.
   typedef struct packed {
      logic [31:0] g;
      logic [4:0]  p;
      logic [30:0] x;
      logic [15:0] frac;
   } log_type;

   // Item in flight through the exp2 cells.
   typedef struct packed {
      logic [31:0]        g;
      logic signed [10:0] i;
      logic [15:0]        f;
      logic [30:0]        m;
   } exp_type;

   // Item in flight through the divider cells.
   typedef struct packed {
      logic [31:0] g;
      logic [31:0] rem;
      logic [31:0] lowq;
      logic        sat;
   } div_type;

   // Position of the highest set bit.
   function automatic logic [4:0] msb_pos(input logic [31:0] v);
      logic [4:0] p;
      p = '0;
      for (int b = 0; b < 32; b++) begin
         if (v[b]) begin
            p = 5'(b);
         end
      end
      return p;
   endfunction

   // Truncated integer square root, evaluated at elaboration only.
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = v_in;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int n = 0; n < 32; n++) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Q1.30 value of 2^(2^-k), built by repeated square roots from 2.
   function automatic logic [30:0] pow_factor(input int k);
      logic [63:0] r;
      r = 64'd2 << 30;
      for (int n = 1; n <= k; n++) begin
         r = isqrt64(r << 30);
      end
      return r[30:0];
   endfunction

endpackage

FILE: rtl/hbv_log_cell.sv
// One squaring step of the log2 fraction: yields one fraction bit.
// Depends on hbv_pkg.
module hbv_log_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  hbv_pkg::log_type in_data,
   output logic             out_valid,
   output hbv_pkg::log_type out_data
);

   logic             valid_ff;
   hbv_pkg::log_type data_ff;
   hbv_pkg::log_type data_in;
   logic [61:0]      sq;
   logic [31:0]      y;

   always_comb begin
      sq      = 62'(in_data.x) * 62'(in_data.x);
      y       = sq[61:30];
      data_in = in_data;
      data_in.frac = {in_data.frac[14:0], y[31]};
      data_in.x    = y[31] ? y[31:1] : y[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/hbv_exp_cell.sv
// One conditional multiply of the exp2 mantissa by 2^(2^-K).
// Depends on hbv_pkg.
module hbv_exp_cell #(
   parameter int K = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  hbv_pkg::exp_type in_data,
   output logic             out_valid,
   output hbv_pkg::exp_type out_data
);

   localparam logic [30:0] FACTOR = hbv_pkg::pow_factor(K);

   logic             valid_ff;
   hbv_pkg::exp_type data_ff;
   hbv_pkg::exp_type data_in;
   logic [61:0]      prod;

   always_comb begin
      prod    = 62'(in_data.m) * 62'(FACTOR);
      data_in = in_data;
      if (in_data.f[16-K]) begin
         data_in.m = prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/hbv_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on hbv_pkg.
module hbv_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  hbv_pkg::div_type in_data,
   output logic             out_valid,
   output hbv_pkg::div_type out_data
);

   logic             valid_ff;
   hbv_pkg::div_type data_ff;
   hbv_pkg::div_type data_in;
   logic [32:0]      r2;
   logic [32:0]      diff;
   logic             ge;

   always_comb begin
      r2      = {in_data.rem, in_data.lowq[31]};
      diff    = r2 - {1'b0, in_data.g};
      ge      = r2 >= {1'b0, in_data.g};
      data_in = in_data;
      data_in.rem  = ge ? diff[31:0] : r2[31:0];
      data_in.lowq = {in_data.lowq[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/herschel_bulkley_viscosity.sv
// Items flow through clamp, log2, exp2, K*m, scale, yield and divide to rsp_.
// Throughput: one item per cycle; the whole cell chain advances together and
// holds only while a finished result is stalled on the output.
// Reset clears every valid bit and loads the configuration registers with
// their defaults. Depends on hbv_pkg, hbv_log_cell, hbv_exp_cell, hbv_div_cell.
module herschel_bulkley_viscosity (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_rate_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_viscosity_out,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int NL = hbv_pkg::LOG_STEPS;
   localparam int NE = hbv_pkg::EXP_STEPS;
   localparam int ND = hbv_pkg::DIV_STEPS;

   logic [31:0] min_rate_ff, max_rate_ff, consistency_ff, yield_level_ff;
   logic [15:0] flow_exponent_ff;

   logic en;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_rate_ff      <= hbv_pkg::MIN_RATE_RESET;
         max_rate_ff      <= hbv_pkg::MAX_RATE_RESET;
         consistency_ff   <= hbv_pkg::CONSISTENCY_RESET;
         flow_exponent_ff <= hbv_pkg::FLOW_EXPONENT_RESET;
         yield_level_ff   <= hbv_pkg::YIELD_LEVEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            hbv_pkg::REG_MIN_RATE:      min_rate_ff      <= csr_data;
            hbv_pkg::REG_MAX_RATE:      max_rate_ff      <= csr_data;
            hbv_pkg::REG_CONSISTENCY:   consistency_ff   <= csr_data;
            hbv_pkg::REG_FLOW_EXPONENT: flow_exponent_ff <= csr_data[15:0];
            hbv_pkg::REG_YIELD_LEVEL:   yield_level_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- clamp ----------------
   logic        v0_ff;
   logic [31:0] g0_ff;
   logic [31:0] g0_in;
   logic [31:0] g_hi;

   always_comb begin
      g_hi  = (req_rate_in > max_rate_ff) ? max_rate_ff : req_rate_in;
      g0_in = (g_hi < min_rate_ff) ? min_rate_ff : g_hi;
      if (g0_in == 32'd0) begin
         g0_in = 32'd1;
      end
   end

   // ---------------- normalize ----------------
   hbv_pkg::log_type log_s [NL+1];
   logic [NL:0]      log_v;
   hbv_pkg::log_type log0_in;
   hbv_pkg::log_type log0_ff;
   logic             log0_valid_ff;
   logic [4:0]       p0;
   logic [31:0]      shifted;

   always_comb begin
      p0      = hbv_pkg::msb_pos(g0_ff);
      shifted = g0_ff << (5'd30 - p0);
      log0_in.g    = g0_ff;
      log0_in.p    = p0;
      log0_in.x    = (p0 == 5'd31) ? g0_ff[31:1] : shifted[30:0];
      log0_in.frac = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         log0_valid_ff <= 1'b0;
      end else if (en) begin
         v0_ff         <= req_valid;
         log0_valid_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g0_ff   <= g0_in;
         log0_ff <= log0_in;
      end
   end

   assign log_v[0] = log0_valid_ff;
   assign log_s[0] = log0_ff;

   for (genvar k = 0; k < NL; k++) begin : g_log
      hbv_log_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (log_v[k]),
         .in_data   (log_s[k]),
         .out_valid (log_v[k+1]),
         .out_data  (log_s[k+1])
      );
   end

   // ---------------- t = n * log2 g ----------------
   hbv_pkg::exp_type exp_s [NE+1];
   logic [NE:0]      exp_v;
   hbv_pkg::exp_type exp0_in;
   hbv_pkg::exp_type exp0_ff;
   logic             exp0_valid_ff;
   logic signed [5:0]  lg_int;
   logic signed [21:0] lg;
   logic signed [38:0] tprod;
   logic signed [26:0] t;

   always_comb begin
      lg_int = $signed({1'b0, log_s[NL].p}) - 6'sd16;
      lg     = {lg_int, log_s[NL].frac};
      tprod  = $signed({1'b0, flow_exponent_ff}) * lg;
      // Arithmetic shift gives the floor of the scaled product.
      t      = 27'(tprod >>> 12);
      exp0_in.g = log_s[NL].g;
      exp0_in.i = 11'(t >>> 16);
      exp0_in.f = t[15:0];
      exp0_in.m = 31'h4000_0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp0_valid_ff <= 1'b0;
      end else if (en) begin
         exp0_valid_ff <= log_v[NL];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         exp0_ff <= exp0_in;
      end
   end

   assign exp_v[0] = exp0_valid_ff;
   assign exp_s[0] = exp0_ff;

   for (genvar k = 1; k <= NE; k++) begin : g_exp
      hbv_exp_cell #(.K(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (exp_v[k-1]),
         .in_data   (exp_s[k-1]),
         .out_valid (exp_v[k]),
         .out_data  (exp_s[k])
      );
   end

   // ---------------- K * m ----------------
   logic               v3_ff;
   logic [62:0]        a3_ff;
   logic signed [10:0] i3_ff;
   logic [31:0]        g3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= exp_v[NE];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a3_ff <= 63'(consistency_ff) * 63'(exp_s[NE].m);
         i3_ff <= exp_s[NE].i;
         g3_ff <= exp_s[NE].g;
      end
   end

   // ---------------- scale by 2^(i-14) ----------------
   logic               v4_ff, sat4_ff, sat4_in;
   logic [63:0]        term4_ff, term4_in;
   logic [31:0]        g4_ff;
   logic signed [11:0] s;
   logic [11:0]        neg;
   logic [126:0]       wide;

   always_comb begin
      s        = $signed({i3_ff[10], i3_ff}) - 12'sd14;
      neg      = 12'(-s);
      wide     = {64'd0, a3_ff} << s[5:0];
      sat4_in  = 1'b0;
      term4_in = '0;
      if (a3_ff == 63'd0) begin
         term4_in = '0;
      end else if (!s[11]) begin
         if (s >= 12'sd63 || (|wide[126:64])) begin
            term4_in = '1;
            sat4_in  = 1'b1;
         end else begin
            term4_in = wide[63:0];
         end
      end else if (neg >= 12'd64) begin
         term4_in = '0;
      end else begin
         term4_in = {1'b0, a3_ff} >> neg[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term4_ff <= term4_in;
         sat4_ff  <= sat4_in;
         g4_ff    <= g3_ff;
      end
   end

   // ---------------- add yield ----------------
   logic        v5_ff, sat5_ff;
   logic [63:0] num5_ff;
   logic [31:0] g5_ff;
   logic [64:0] sum;

   assign sum = {1'b0, term4_ff} + {17'd0, yield_level_ff, 16'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num5_ff <= sum[63:0];
         sat5_ff <= sat4_ff | sum[64];
         g5_ff   <= g4_ff;
      end
   end

   // ---------------- divide ----------------
   hbv_pkg::div_type div_s [ND+1];
   logic [ND:0]      div_v;
   hbv_pkg::div_type div0_in;
   hbv_pkg::div_type div0_ff;
   logic             div0_valid_ff;

   // A high half at or above g means the quotient does not fit in 32 bits.
   always_comb begin
      div0_in.g    = g5_ff;
      div0_in.rem  = num5_ff[63:32];
      div0_in.lowq = num5_ff[31:0];
      div0_in.sat  = sat5_ff | (num5_ff[63:32] >= g5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div0_valid_ff <= 1'b0;
      end else if (en) begin
         div0_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div0_ff <= div0_in;
      end
   end

   assign div_v[0] = div0_valid_ff;
   assign div_s[0] = div0_ff;

   for (genvar k = 0; k < ND; k++) begin : g_div
      hbv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (div_v[k]),
         .in_data   (div_s[k]),
         .out_valid (div_v[k+1]),
         .out_data  (div_s[k+1])
      );
   end

   // ---------------- output register ----------------
   logic        out_valid_ff;
   logic [31:0] out_visc_ff;
   logic        out_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= div_v[ND];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_visc_ff <= div_s[ND].sat ? 32'hFFFF_FFFF : div_s[ND].lowq;
         out_sat_ff  <= div_s[ND].sat;
      end
   end

   assign en                = !out_valid_ff || !rsp_stall;
   assign req_stall         = !en;
   assign rsp_valid         = out_valid_ff;
   assign rsp_viscosity_out = out_visc_ff;
   assign rsp_saturated     = out_sat_ff;

endmodule
